// ===== hdl/dpgc_pkg.sv =====
package dpgc_pkg;

  localparam int unsigned MAX_ELEMENTS = 4096;

  localparam logic [31:0] CLIP_RESET  = 32'd65536;
  localparam logic [31:0] EPS_RESET   = 32'd16777216;
  localparam logic [31:0] TOTAL_RESET = 32'd83886080;
  localparam logic [63:0] SEED_RESET  = 64'd1;

  localparam logic [63:0] MIX_GOLDEN = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX_K1     = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_K2     = 64'h94D049BB133111EB;

  localparam logic [52:0] HALF53  = 53'h10000000000000;
  localparam logic [52:0] A_LIMIT = HALF53 - 53'd9008;
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam logic [31:0] M32     = 32'hFFFFFFFF;

  localparam int unsigned SQ_W      = 82;
  localparam int unsigned ROOT_W    = 41;
  localparam int unsigned DIV_W     = 57;
  localparam int unsigned LOG_STEPS = 26;

  localparam logic [1:0] CFG_CLIP  = 2'd0;
  localparam logic [1:0] CFG_EPS   = 2'd1;
  localparam logic [1:0] CFG_TOTAL = 2'd2;
  localparam logic [1:0] CFG_SEED  = 2'd3;

  typedef enum logic [1:0] {
    STAT_OK  = 2'd0,
    STAT_BAD = 2'd1,
    STAT_EXH = 2'd2
  } status_t;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    mag32 = v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic [31:0] mag33(input logic [32:0] v);
    logic [32:0] m;
    m = v[32] ? (~v + 33'd1) : v;
    mag33 = m[31:0];
  endfunction

  function automatic logic [31:0] sat32(input logic [ROOT_W-1:0] v);
    sat32 = (v > ROOT_W'(M32)) ? M32 : v[31:0];
  endfunction

endpackage

// ===== hdl/dpgc_ram.sv =====
module dpgc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/dp_gradient_clip_and_noise.sv =====
// Differentially private gradient round: L2 clipping plus Laplace noise.
// Command port: an item is taken when start is high and busy is low.
// mode 0 loads grad_value into the element store; is_last on a
// load closes the vector and runs the round, during which busy stays high.
// mode 1 drains the next perturbed element: done pulses from the ST_DRAIN
// state with out_value and drain_last; a drain with nothing left gives
// no result. The round ends with one report beat (status, norms, budget).
// Every result is shown for one cycle under done; the receiver cannot stall.
// Config: wr_en/wr_index/wr_data writes a register at once; a seed write
// reloads the generator. Write only while busy is low.
// Round for n elements: one shared 32x32 multiplier, a 41-step
// square root and a 57-step divider do all the math. A norm pass, a clip
// pass and a noise pass (normalize shift plus 26 squaring steps of the
// log per element) visit each element, with four roots and up to three
// divides. A budget-exhausted round copies the store. Reset clears counters
// and spent budget and resets config and seed; the stores are not cleared.
module dp_gradient_clip_and_noise #(
  parameter int unsigned MAX_ELEMENTS = dpgc_pkg::MAX_ELEMENTS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output logic               done,
  input  logic               mode,
  input  logic signed [31:0] grad_value,
  input  logic               is_last,
  input  logic               wr_en,
  input  logic [1:0]         wr_index,
  input  logic [63:0]        wr_data,
  output logic signed [31:0] out_value,
  output logic [1:0]         status,
  output logic [23:0]        clip_factor,
  output logic [31:0]        lap_scale,
  output logic [31:0]        norm_in,
  output logic [31:0]        norm_clip,
  output logic [31:0]        norm_noisy,
  output logic [31:0]        noise_norm,
  output logic [16:0]        sigma_ratio,
  output logic signed [32:0] budget_left,
  output logic               budget_gone,
  output logic               drain_last
);

  localparam int unsigned AW    = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int unsigned CW    = $clog2(MAX_ELEMENTS + 2);
  localparam int unsigned ACC_W = 64 + CW;
  localparam int unsigned RW    = dpgc_pkg::ROOT_W;
  localparam int unsigned QW    = dpgc_pkg::DIV_W;
  localparam int unsigned XW    = dpgc_pkg::SQ_W;
  localparam logic [CW-1:0] MAX_N = CW'(MAX_ELEMENTS);

  typedef enum logic [39:0] {
    ST_IDLE     = 40'd1 << 0,
    ST_DRAIN    = 40'd1 << 1,
    ST_ROUND    = 40'd1 << 2,
    ST_COPY_RD  = 40'd1 << 3,
    ST_COPY_WR  = 40'd1 << 4,
    ST_P1_RD    = 40'd1 << 5,
    ST_P1_MUL   = 40'd1 << 6,
    ST_P1_ACC   = 40'd1 << 7,
    ST_SQRT     = 40'd1 << 8,
    ST_DIV      = 40'd1 << 9,
    ST_FACTOR   = 40'd1 << 10,
    ST_FACTOR_Q = 40'd1 << 11,
    ST_P2_RD    = 40'd1 << 12,
    ST_P2_MUL1  = 40'd1 << 13,
    ST_P2_MUL2  = 40'd1 << 14,
    ST_P2_ACC   = 40'd1 << 15,
    ST_SCALE    = 40'd1 << 16,
    ST_SCALE_Q  = 40'd1 << 17,
    ST_N_RD     = 40'd1 << 18,
    ST_MX0      = 40'd1 << 19,
    ST_MX1      = 40'd1 << 20,
    ST_MX2      = 40'd1 << 21,
    ST_MX3      = 40'd1 << 22,
    ST_MIXED    = 40'd1 << 23,
    ST_NORM     = 40'd1 << 24,
    ST_LOG_SQ   = 40'd1 << 25,
    ST_LOG_UPD  = 40'd1 << 26,
    ST_LN_T     = 40'd1 << 27,
    ST_LN_MUL   = 40'd1 << 28,
    ST_LN_RND   = 40'd1 << 29,
    ST_NM_MUL   = 40'd1 << 30,
    ST_NM_RND   = 40'd1 << 31,
    ST_PERT     = 40'd1 << 32,
    ST_PSQ      = 40'd1 << 33,
    ST_DSQ      = 40'd1 << 34,
    ST_N_ACC    = 40'd1 << 35,
    ST_PN       = 40'd1 << 36,
    ST_NN       = 40'd1 << 37,
    ST_SIGMA_Q  = 40'd1 << 38,
    ST_REPORT   = 40'd1 << 39
  } state_t;

  state_t state, sq_ret, dv_ret;

  logic [CW-1:0] count, round_n, idx, drain_index, drain_len;
  logic [31:0]   clip_limit, round_epsilon, total_epsilon, spent;
  logic [63:0]   gs;
  dpgc_pkg::status_t rep_status;

  logic [ACC_W-1:0] acc, nacc;
  logic [63:0]      mul_p;
  logic [31:0]      mul_a, mul_b;

  logic [XW-1:0] sq_x;
  logic [42:0]   sq_rem;
  logic [RW-1:0] sq_root;
  logic [5:0]    sq_cnt;
  logic [QW-1:0] dv_q;
  logic [RW-1:0] dv_rem, dv_d;
  logic [5:0]    dv_cnt;

  logic [RW-1:0] pre, post, pn;
  logic [23:0]   factor;
  logic [31:0]   scale;
  logic [16:0]   sigma;
  logic          sgn;

  logic [63:0]        z, zacc;
  logic               mix_sel;
  logic signed [31:0] c_val, p_val;
  logic signed [32:0] d_val;
  logic               neg;
  logic [52:0]        y53;
  logic [5:0]         e;
  logic [31:0]        y, tt, lval;
  logic [25:0]        frac;
  logic [4:0]         log_i;
  logic [38:0]        nm;

  logic [31:0] clip_rdata, pert_rdata;

  // combinational helpers
  logic          clip_we, pert_we;
  logic [AW-1:0] clip_waddr;
  logic [31:0]   clip_wdata, pert_wdata;
  logic [CW-1:0] count_inc;
  logic          idx_last;
  logic [31:0]   cm;
  logic [63:0]   kconst, gnext, prod;
  logic [52:0]   mval, a_raw, a_cl;
  logic [44:0]   sq_r2, sq_trial;
  logic          sq_take;
  logic [RW:0]   dv_r2;
  logic          dv_ge;
  logic [31:0]   t_val;
  logic signed [40:0] p_raw;
  logic [31:0]   p_sat;
  logic [32:0]   spent_eps;
  logic [33:0]   left34;
  logic [ACC_W-1:0] acc_sum;

  assign busy      = (state != ST_IDLE);
  assign count_inc = (count <= MAX_N) ? count + 1'b1 : count;
  assign idx_last  = ((idx + 1'b1) == round_n);
  assign cm        = mul_p[54:23];
  assign kconst    = mix_sel ? dpgc_pkg::MIX_K2 : dpgc_pkg::MIX_K1;
  assign gnext     = gs + dpgc_pkg::MIX_GOLDEN;
  assign prod      = zacc + {mul_p[31:0], 32'd0};
  assign mval      = z[63:11];
  assign a_raw     = (mval < dpgc_pkg::HALF53) ? dpgc_pkg::HALF53 - mval
                                               : mval - dpgc_pkg::HALF53;
  assign a_cl      = (a_raw > dpgc_pkg::A_LIMIT) ? dpgc_pkg::A_LIMIT : a_raw;
  assign acc_sum   = acc + ACC_W'(mul_p);
  assign spent_eps = {1'b0, spent} + {1'b0, round_epsilon};
  assign left34    = {2'b00, total_epsilon}
                   - ((rep_status == dpgc_pkg::STAT_OK) ? {1'b0, spent_eps}
                                                        : {2'b00, spent});

  assign sq_r2    = {sq_rem, sq_x[XW-1 -: 2]};
  assign sq_trial = {2'b00, sq_root, 2'b01};
  assign sq_take  = (sq_r2 >= sq_trial);
  assign dv_r2    = {dv_rem, dv_q[QW-1]};
  assign dv_ge    = (dv_r2 >= {1'b0, dv_d});

  assign t_val = {6'(6'd52 - e), 26'd0};
  assign p_raw = neg ? (41'(c_val) - $signed({2'b00, nm}))
                     : (41'(c_val) + $signed({2'b00, nm}));
  always_comb begin
    if (p_raw > 41'sd2147483647) begin
      p_sat = 32'h7FFFFFFF;
    end else if (p_raw < -41'sd2147483648) begin
      p_sat = 32'h80000000;
    end else begin
      p_sat = p_raw[31:0];
    end
  end

  assign clip_we    = ((state == ST_IDLE) && start && !mode && (count < MAX_N))
                   || (state == ST_P2_MUL2);
  assign clip_waddr = (state == ST_IDLE) ? count[AW-1:0] : idx[AW-1:0];
  assign clip_wdata = (state == ST_IDLE) ? grad_value : (sgn ? (~cm + 32'd1) : cm);
  assign pert_we    = (state == ST_COPY_WR) || (state == ST_PERT);
  assign pert_wdata = (state == ST_PERT) ? p_sat : clip_rdata;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_P1_MUL: begin
        mul_a = dpgc_pkg::mag32(clip_rdata);
        mul_b = dpgc_pkg::mag32(clip_rdata);
      end
      ST_P2_MUL1: begin
        mul_a = dpgc_pkg::mag32(clip_rdata);
        mul_b = {8'd0, factor};
      end
      ST_P2_MUL2: begin
        mul_a = cm;
        mul_b = cm;
      end
      ST_MX0: begin
        mul_a = z[31:0];
        mul_b = kconst[31:0];
      end
      ST_MX1: begin
        mul_a = z[31:0];
        mul_b = kconst[63:32];
      end
      ST_MX2: begin
        mul_a = z[63:32];
        mul_b = kconst[31:0];
      end
      ST_LOG_SQ: begin
        mul_a = y;
        mul_b = y;
      end
      ST_LN_MUL: begin
        mul_a = tt;
        mul_b = dpgc_pkg::LN2_Q32;
      end
      ST_NM_MUL: begin
        mul_a = scale;
        mul_b = lval;
      end
      ST_PSQ: begin
        mul_a = dpgc_pkg::mag32(p_val);
        mul_b = dpgc_pkg::mag32(p_val);
      end
      ST_DSQ: begin
        mul_a = dpgc_pkg::mag33(d_val);
        mul_b = dpgc_pkg::mag33(d_val);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
  end

  dpgc_ram #(.WIDTH(32), .DEPTH(MAX_ELEMENTS)) u_clip_ram (
    .clk   (clk),
    .we    (clip_we),
    .waddr (clip_waddr),
    .wdata (clip_wdata),
    .raddr (idx[AW-1:0]),
    .rdata (clip_rdata)
  );

  dpgc_ram #(.WIDTH(32), .DEPTH(MAX_ELEMENTS)) u_pert_ram (
    .clk   (clk),
    .we    (pert_we),
    .waddr (idx[AW-1:0]),
    .wdata (pert_wdata),
    .raddr (drain_index[AW-1:0]),
    .rdata (pert_rdata)
  );

  // configuration registers and generator
  always_ff @(posedge clk) begin
    if (rst) begin
      clip_limit    <= dpgc_pkg::CLIP_RESET;
      round_epsilon <= dpgc_pkg::EPS_RESET;
      total_epsilon <= dpgc_pkg::TOTAL_RESET;
      gs            <= dpgc_pkg::SEED_RESET;
    end else if (wr_en) begin
      case (wr_index)
        dpgc_pkg::CFG_CLIP:  clip_limit    <= wr_data[31:0];
        dpgc_pkg::CFG_EPS:   round_epsilon <= wr_data[31:0];
        dpgc_pkg::CFG_TOTAL: total_epsilon <= wr_data[31:0];
        dpgc_pkg::CFG_SEED:  gs <= (wr_data == 64'd0) ? 64'd1 : wr_data;
        default: ;
      endcase
    end else if (state == ST_N_RD) begin
      gs <= gnext;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      count       <= '0;
      drain_index <= '0;
      drain_len   <= '0;
      spent       <= '0;
      done        <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            if (mode) begin
              if (drain_index < drain_len) begin
                state <= ST_DRAIN;
              end
            end else begin
              count <= count_inc;
              if (is_last) begin
                round_n     <= count_inc;
                count       <= '0;
                drain_index <= '0;
                state       <= ST_ROUND;
              end
            end
          end
        end
        ST_DRAIN: begin
          done        <= 1'b1;
          out_value   <= pert_rdata;
          drain_last  <= ((drain_index + 1'b1) == drain_len);
          status      <= dpgc_pkg::STAT_OK;
          clip_factor <= '0;
          lap_scale   <= '0;
          norm_in     <= '0;
          norm_clip   <= '0;
          norm_noisy  <= '0;
          noise_norm  <= '0;
          sigma_ratio <= '0;
          budget_left <= '0;
          budget_gone <= 1'b0;
          drain_index <= drain_index + 1'b1;
          state       <= ST_IDLE;
        end
        ST_ROUND: begin
          idx <= '0;
          acc <= '0;
          if (round_n > MAX_N) begin
            drain_len  <= '0;
            rep_status <= dpgc_pkg::STAT_BAD;
            state      <= ST_REPORT;
          end else begin
            drain_len <= round_n;
            if (spent_eps > {1'b0, total_epsilon}) begin
              rep_status <= dpgc_pkg::STAT_EXH;
              state      <= ST_COPY_RD;
            end else begin
              rep_status <= dpgc_pkg::STAT_OK;
              state      <= ST_P1_RD;
            end
          end
        end
        ST_COPY_RD: state <= ST_COPY_WR;
        ST_COPY_WR: begin
          idx   <= idx + 1'b1;
          state <= idx_last ? ST_REPORT : ST_COPY_RD;
        end
        ST_P1_RD:  state <= ST_P1_MUL;
        ST_P1_MUL: state <= ST_P1_ACC;
        ST_P1_ACC: begin
          acc <= acc_sum;
          idx <= idx + 1'b1;
          if (idx_last) begin
            sq_x   <= XW'(acc_sum);
            sq_rem <= '0;
            sq_root <= '0;
            sq_cnt <= '0;
            sq_ret <= ST_FACTOR;
            state  <= ST_SQRT;
          end else begin
            state <= ST_P1_RD;
          end
        end
        ST_SQRT: begin
          sq_rem  <= sq_take ? 43'(sq_r2 - sq_trial) : 43'(sq_r2);
          sq_root <= {sq_root[RW-2:0], sq_take};
          sq_x    <= {sq_x[XW-3:0], 2'b00};
          sq_cnt  <= sq_cnt + 1'b1;
          if (sq_cnt == 6'(RW - 1)) begin
            state <= sq_ret;
          end
        end
        ST_DIV: begin
          dv_rem <= dv_ge ? RW'(dv_r2 - {1'b0, dv_d}) : dv_r2[RW-1:0];
          dv_q   <= {dv_q[QW-2:0], dv_ge};
          dv_cnt <= dv_cnt + 1'b1;
          if (dv_cnt == 6'(QW - 1)) begin
            state <= dv_ret;
          end
        end
        ST_FACTOR: begin
          pre <= sq_root;
          acc <= '0;
          idx <= '0;
          if (sq_root > RW'(clip_limit)) begin
            dv_q   <= {2'b00, clip_limit, 23'd0};
            dv_d   <= sq_root;
            dv_rem <= '0;
            dv_cnt <= '0;
            dv_ret <= ST_FACTOR_Q;
            state  <= ST_DIV;
          end else begin
            factor <= 24'h800000;
            state  <= ST_P2_RD;
          end
        end
        ST_FACTOR_Q: begin
          factor <= dv_q[23:0];
          state  <= ST_P2_RD;
        end
        ST_P2_RD: state <= ST_P2_MUL1;
        ST_P2_MUL1: begin
          sgn   <= clip_rdata[31];
          state <= ST_P2_MUL2;
        end
        ST_P2_MUL2: state <= ST_P2_ACC;
        ST_P2_ACC: begin
          acc <= acc_sum;
          idx <= idx + 1'b1;
          if (idx_last) begin
            sq_x    <= XW'(acc_sum);
            sq_rem  <= '0;
            sq_root <= '0;
            sq_cnt  <= '0;
            sq_ret  <= ST_SCALE;
            state   <= ST_SQRT;
          end else begin
            state <= ST_P2_RD;
          end
        end
        ST_SCALE: begin
          post <= sq_root;
          idx  <= '0;
          acc  <= '0;
          nacc <= '0;
          if (round_epsilon == 32'd0) begin
            scale <= dpgc_pkg::M32;
            state <= ST_N_RD;
          end else begin
            dv_q   <= {1'b0, clip_limit, 24'd0};
            dv_d   <= RW'(round_epsilon);
            dv_rem <= '0;
            dv_cnt <= '0;
            dv_ret <= ST_SCALE_Q;
            state  <= ST_DIV;
          end
        end
        ST_SCALE_Q: begin
          scale <= (dv_q > QW'(dpgc_pkg::M32)) ? dpgc_pkg::M32 : dv_q[31:0];
          state <= ST_N_RD;
        end
        ST_N_RD: begin
          z       <= gnext ^ (gnext >> 30);
          mix_sel <= 1'b0;
          state   <= ST_MX0;
        end
        ST_MX0: state <= ST_MX1;
        ST_MX1: begin
          zacc  <= mul_p;
          state <= ST_MX2;
        end
        ST_MX2: begin
          zacc  <= prod;
          state <= ST_MX3;
        end
        ST_MX3: begin
          if (!mix_sel) begin
            z       <= prod ^ (prod >> 27);
            mix_sel <= 1'b1;
            state   <= ST_MX0;
          end else begin
            z     <= prod ^ (prod >> 31);
            state <= ST_MIXED;
          end
        end
        ST_MIXED: begin
          c_val <= clip_rdata;
          neg   <= (mval < dpgc_pkg::HALF53);
          y53   <= dpgc_pkg::HALF53 - a_cl;
          e     <= 6'd52;
          state <= ST_NORM;
        end
        ST_NORM: begin
          if (y53[52]) begin
            y     <= {1'b0, y53[52:22]};
            frac  <= '0;
            log_i <= '0;
            state <= ST_LOG_SQ;
          end else begin
            y53 <= {y53[51:0], 1'b0};
            e   <= e - 1'b1;
          end
        end
        ST_LOG_SQ: state <= ST_LOG_UPD;
        ST_LOG_UPD: begin
          if (mul_p[61]) begin
            y    <= mul_p[62:31];
            frac <= frac | (26'd1 << (5'd25 - log_i));
          end else begin
            y <= mul_p[61:30];
          end
          log_i <= log_i + 1'b1;
          state <= (log_i == 5'(dpgc_pkg::LOG_STEPS - 1)) ? ST_LN_T : ST_LOG_SQ;
        end
        ST_LN_T: begin
          tt    <= (t_val > {6'd0, frac}) ? t_val - {6'd0, frac} : 32'd0;
          state <= ST_LN_MUL;
        end
        ST_LN_MUL: state <= ST_LN_RND;
        ST_LN_RND: begin
          lval  <= 32'((65'(mul_p) + 65'h80000000) >> 32);
          state <= ST_NM_MUL;
        end
        ST_NM_MUL: state <= ST_NM_RND;
        ST_NM_RND: begin
          nm    <= 39'((65'(mul_p) + 65'h2000000) >> 26);
          state <= ST_PERT;
        end
        ST_PERT: begin
          p_val <= p_sat;
          state <= ST_PSQ;
        end
        ST_PSQ: begin
          d_val <= 33'(p_val) - 33'(c_val);
          state <= ST_DSQ;
        end
        ST_DSQ: begin
          acc   <= acc_sum;
          state <= ST_N_ACC;
        end
        ST_N_ACC: begin
          nacc <= nacc + ACC_W'(mul_p);
          idx  <= idx + 1'b1;
          if (idx_last) begin
            sq_x    <= XW'(acc);
            sq_rem  <= '0;
            sq_root <= '0;
            sq_cnt  <= '0;
            sq_ret  <= ST_PN;
            state   <= ST_SQRT;
          end else begin
            state <= ST_N_RD;
          end
        end
        ST_PN: begin
          pn      <= sq_root;
          sq_x    <= XW'(nacc);
          sq_rem  <= '0;
          sq_root <= '0;
          sq_cnt  <= '0;
          sq_ret  <= ST_NN;
          state   <= ST_SQRT;
        end
        ST_NN: begin
          if (sq_root == '0) begin
            sigma <= '0;
            state <= ST_REPORT;
          end else if (sq_root >= post) begin
            sigma <= 17'h10000;
            state <= ST_REPORT;
          end else begin
            dv_q   <= {sq_root, 16'd0};
            dv_d   <= post;
            dv_rem <= '0;
            dv_cnt <= '0;
            dv_ret <= ST_SIGMA_Q;
            state  <= ST_DIV;
          end
        end
        ST_SIGMA_Q: begin
          sigma <= dv_q[16:0];
          state <= ST_REPORT;
        end
        ST_REPORT: begin
          done        <= 1'b1;
          out_value   <= '0;
          drain_last  <= 1'b0;
          status      <= rep_status;
          budget_left <= '0;
          budget_gone <= 1'b0;
          if (rep_status == dpgc_pkg::STAT_OK) begin
            clip_factor <= factor;
            lap_scale   <= scale;
            norm_in     <= dpgc_pkg::sat32(pre);
            norm_clip   <= dpgc_pkg::sat32(post);
            norm_noisy  <= dpgc_pkg::sat32(pn);
            noise_norm  <= dpgc_pkg::sat32(sq_root);
            sigma_ratio <= sigma;
            budget_left <= left34[32:0];
            budget_gone <= ($signed(left34) < $signed({2'b00, round_epsilon}));
            spent       <= spent_eps[31:0];
          end else begin
            clip_factor <= '0;
            lap_scale   <= '0;
            norm_in     <= '0;
            norm_clip   <= '0;
            norm_noisy  <= '0;
            noise_norm  <= '0;
            sigma_ratio <= '0;
            if (rep_status == dpgc_pkg::STAT_EXH) begin
              budget_left <= left34[32:0];
              budget_gone <= 1'b1;
            end
          end
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
